>>> design/avnq_pkg.sv
`timescale 1ns / 1ps

package avnq_pkg;

	// Sample width of each axis, two's complement
	localparam int SAMPLE_WIDTH = 16;

	// Direction scale and the number of quotient bits that cover it
	localparam int DIR_SCALE = 127;
	localparam int Q_BITS    = 7;

	// Internal widths: magnitude, square, sum of squares, products
	localparam int MAG_W = SAMPLE_WIDTH;
	localparam int M2_W  = 2 * SAMPLE_WIDTH - 1;
	localparam int SUM_W = 2 * SAMPLE_WIDTH;
	localparam int QS_W  = SUM_W + Q_BITS;
	localparam int P_W   = SUM_W + 2 * Q_BITS;

	// Search steps and pipeline latency from accept edge to result edge
	localparam int N_STEPS = Q_BITS;
	localparam int LATENCY = N_STEPS + 4;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] accel_x;
		logic signed [SAMPLE_WIDTH-1:0] accel_y;
		logic signed [SAMPLE_WIDTH-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [7:0] dir_x;
		logic signed [7:0] dir_y;
		logic signed [7:0] dir_z;
		logic              zero_vector;
	} result_t;

	// Squared axis values after the front end
	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][M2_W-1:0]  m2;
	} sq_t;

	// One axis of the quotient search: q, q*q*S, q*S and the bound
	typedef struct packed {
		logic              neg;
		logic [Q_BITS-1:0] q;
		logic [P_W-1:0]    p;
		logic [QS_W-1:0]   qs;
		logic [P_W-1:0]    r;
	} lane_t;

	typedef struct packed {
		logic             zero;
		logic [SUM_W-1:0] s;
		lane_t [2:0]      lane;
	} step_t;

endpackage

>>> design/avnq_prep.sv
`timescale 1ns / 1ps

module avnq_prep import avnq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_vld,
	input  sample_t in_dat,
	output logic    out_vld,
	output sq_t     out_dat
);

	logic [2:0][SAMPLE_WIDTH-1:0] raw;
	logic [2:0][MAG_W-1:0]        mag_s1;
	logic [2:0]                   neg_s1;
	logic                         vld_s1;
	logic [2:0][2*MAG_W-1:0]      sq_full;
	sq_t                          sq_s2;
	logic                         vld_s2;

	assign raw[0] = in_dat.accel_x;
	assign raw[1] = in_dat.accel_y;
	assign raw[2] = in_dat.accel_z;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: take magnitude and sign; the most negative value maps to 2^(W-1)
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= raw[i][SAMPLE_WIDTH-1];
			mag_s1[i] <= raw[i][SAMPLE_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
		end
	end

	// Stage 2: square each magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full[i] = mag_s1[i] * mag_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		sq_s2.neg <= neg_s1;
		for (int i = 0; i < 3; i++) begin
			sq_s2.m2[i] <= sq_full[i][M2_W-1:0];
		end
	end

	assign out_vld = vld_s2;
	assign out_dat = sq_s2;

endmodule

>>> design/avnq_sumsq.sv
`timescale 1ns / 1ps

module avnq_sumsq import avnq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  sq_t   in_dat,
	output logic  out_vld,
	output step_t out_dat
);

	logic [SUM_W-1:0] sum;
	step_t            acc_s3;
	logic             vld_s3;

	assign sum = SUM_W'(in_dat.m2[0]) + SUM_W'(in_dat.m2[1]) + SUM_W'(in_dat.m2[2]);

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= in_vld;
		end
	end

	// Stage 3: form the sum of squares and each axis bound 127^2 * a^2
	always_ff @(posedge clk) begin
		acc_s3.zero <= (sum == '0);
		acc_s3.s    <= sum;
		for (int i = 0; i < 3; i++) begin
			acc_s3.lane[i].neg <= in_dat.neg[i];
			acc_s3.lane[i].q   <= '0;
			acc_s3.lane[i].p   <= '0;
			acc_s3.lane[i].qs  <= '0;
			acc_s3.lane[i].r   <= P_W'(in_dat.m2[i]) * P_W'(DIR_SCALE * DIR_SCALE);
		end
	end

	assign out_vld = vld_s3;
	assign out_dat = acc_s3;

endmodule

>>> design/avnq_qstep.sv
`timescale 1ns / 1ps

module avnq_qstep import avnq_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  step_t in_dat,
	output logic  out_vld,
	output step_t out_dat
);

	localparam int BIT_POS = Q_BITS - 1 - STEP;

	logic [2:0][P_W-1:0] cand;
	logic [2:0]          take;
	step_t               step_sn;
	logic                vld_sn;

	// Trial bit: (q+b)^2*S = q^2*S + 2b*q*S + b^2*S, all by shifts and adds
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cand[i] = in_dat.lane[i].p
				+ (P_W'(in_dat.lane[i].qs) << (BIT_POS + 1))
				+ (P_W'(in_dat.s) << (2 * BIT_POS));
			take[i] = (cand[i] <= in_dat.lane[i].r);
		end
	end

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= in_vld;
		end
	end

	// Keep the trial bit where the product stays within the bound
	always_ff @(posedge clk) begin
		step_sn.zero <= in_dat.zero;
		step_sn.s    <= in_dat.s;
		for (int i = 0; i < 3; i++) begin
			step_sn.lane[i].neg <= in_dat.lane[i].neg;
			step_sn.lane[i].r   <= in_dat.lane[i].r;
			if (take[i]) begin
				step_sn.lane[i].q  <= in_dat.lane[i].q | (Q_BITS'(1) << BIT_POS);
				step_sn.lane[i].p  <= cand[i];
				step_sn.lane[i].qs <= in_dat.lane[i].qs + (QS_W'(in_dat.s) << BIT_POS);
			end else begin
				step_sn.lane[i].q  <= in_dat.lane[i].q;
				step_sn.lane[i].p  <= in_dat.lane[i].p;
				step_sn.lane[i].qs <= in_dat.lane[i].qs;
			end
		end
	end

	assign out_vld = vld_sn;
	assign out_dat = step_sn;

endmodule

>>> design/accel_vector_normalize_quantize.sv
`timescale 1ns / 1ps

// Three-axis sample to unit direction quantized to signed bytes.
// Input channel: drive sample and raise start; the sample transfers at a
// rising edge where start is high and busy is low. busy stays low, so a
// sample may transfer on every cycle.
// Output channel: done is high for exactly one cycle with result valid;
// the result transfers at the edge that ends that cycle. Each component is
// floor(127*|a|/sqrt(x^2+y^2+z^2)) with the sign of a; an all-zero sample
// gives zeros and zero_vector set.
// Throughput: one sample per cycle. The pipeline is three front-end stages
// (magnitude, square, sum and bound), seven quotient search stages of one
// bit each, and an output register.
// Reset clears all valid bits, so no result appears until a new sample has
// travelled the full pipeline. The receiver cannot stall; results are never
// held back.
module accel_vector_normalize_quantize import avnq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t sample,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic                  acc_vld;
	logic                  sq_vld;
	sq_t                   sq_dat;
	logic [N_STEPS:0]      st_vld;
	step_t [N_STEPS:0]     st_dat;
	logic                  done_q;
	result_t               result_q;
	logic [2:0][7:0]       dir;

	assign busy    = 1'b0;
	assign acc_vld = start & ~busy;

	avnq_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc_vld),
		.in_dat  (sample),
		.out_vld (sq_vld),
		.out_dat (sq_dat)
	);

	avnq_sumsq u_sumsq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.in_dat  (sq_dat),
		.out_vld (st_vld[0]),
		.out_dat (st_dat[0])
	);

	// Quotient search, most significant bit first
	for (genvar g = 0; g < N_STEPS; g++) begin : g_step
		avnq_qstep #(.STEP(g)) u_qstep (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (st_vld[g]),
			.in_dat  (st_dat[g]),
			.out_vld (st_vld[g+1]),
			.out_dat (st_dat[g+1])
		);
	end

	// Apply sign, force zeros on an all-zero sample
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (st_dat[N_STEPS].zero) begin
				dir[i] = '0;
			end else if (st_dat[N_STEPS].lane[i].neg) begin
				dir[i] = 8'(0) - {1'b0, st_dat[N_STEPS].lane[i].q};
			end else begin
				dir[i] = {1'b0, st_dat[N_STEPS].lane[i].q};
			end
		end
	end

	// Advance the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= st_vld[N_STEPS];
		end
	end

	// Hold the result for its one cycle
	always_ff @(posedge clk) begin
		result_q.dir_x       <= dir[0];
		result_q.dir_y       <= dir[1];
		result_q.dir_z       <= dir[2];
		result_q.zero_vector <= st_dat[N_STEPS].zero;
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted sample produced no result at the expected edge");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching accepted sample");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_vector) |->
		(result.dir_x == 8'sd0 && result.dir_y == 8'sd0 && result.dir_z == 8'sd0))
		else $error("zero vector flagged with nonzero direction");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.dir_x != -8'sd128 && result.dir_y != -8'sd128 &&
			result.dir_z != -8'sd128))
		else $error("direction component outside the range of plus or minus 127");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
	import avnq_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	sample_t sample;
	logic    busy;
	logic    done;
	result_t result;

	// Predict each direction and match it against the output stream in order
	class dir_scoreboard;
		result_t pending_dirs[$];
		int errors = 0;
		int matched = 0;
		int zero_hits = 0;

		// Largest q <= 127 with q*q*sumsq <= 127*127*a*a, sign of a applied
		function result_t normalize(sample_t s);
			logic signed [SAMPLE_WIDTH-1:0] axis [3];
			longint unsigned mag [3];
			logic [7:0] comp [3];
			longint unsigned sumsq, scale2, bound, t, t_bit, q;
			int i;
			result_t r;
			axis[0] = s.accel_x;
			axis[1] = s.accel_y;
			axis[2] = s.accel_z;
			sumsq = 0;
			scale2 = DIR_SCALE * DIR_SCALE;
			for (i = 0; i < 3; i++) begin
				mag[i] = (axis[i] < 0) ? -longint'(axis[i]) : longint'(axis[i]);
				sumsq += mag[i] * mag[i];
			end
			r = '0;
			// All-zero sample: no division, flag it
			if (sumsq == 0) begin
				r.zero_vector = 1'b1;
				return r;
			end
			for (i = 0; i < 3; i++) begin
				bound = scale2 * mag[i] * mag[i];
				q = 0;
				for (t_bit = 64; t_bit > 0; t_bit >>= 1) begin
					t = q | t_bit;
					if (t <= DIR_SCALE && t * t * sumsq <= bound)
						q = t;
				end
				comp[i] = q[7:0];
				if (axis[i] < 0)
					comp[i] = -comp[i];
			end
			r.dir_x = comp[0];
			r.dir_y = comp[1];
			r.dir_z = comp[2];
			return r;
		endfunction

		function void note_sample(sample_t s);
			pending_dirs.push_back(normalize(s));
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t r);
			result_t want;
			if (pending_dirs.size() == 0) begin
				errors++;
				$display("t=%0t result with nothing pending: expected none, actual %p", $time, r);
				return;
			end
			want = pending_dirs.pop_front();
			compare_field("dir_x", want.dir_x, r.dir_x);
			compare_field("dir_y", want.dir_y, r.dir_y);
			compare_field("dir_z", want.dir_z, r.dir_z);
			compare_field("zero_vector", want.zero_vector, r.zero_vector);
			matched++;
			if (want.zero_vector)
				zero_hits++;
		endfunction
	endclass

	dir_scoreboard sb = new;
	int unsigned cycles = 0;

	accel_vector_normalize_quantize dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (sample),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Sample the result strobe mid-cycle, away from the active edge
	always @(negedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic sample_t pack_sample(logic signed [SAMPLE_WIDTH-1:0] x,
			logic signed [SAMPLE_WIDTH-1:0] y, logic signed [SAMPLE_WIDTH-1:0] z);
		sample_t s;
		s.accel_x = x;
		s.accel_y = y;
		s.accel_z = z;
		return s;
	endfunction

	// Axis value: full range, near zero, extreme, or a shifted byte of random sign
	function automatic logic signed [SAMPLE_WIDTH-1:0] random_axis(int unsigned kind);
		logic signed [SAMPLE_WIDTH-1:0] v;
		case (kind)
			0: begin
				v = SAMPLE_WIDTH'($urandom);
			end
			1: begin
				v = SAMPLE_WIDTH'($urandom_range(0, 16)) - SAMPLE_WIDTH'(8);
			end
			2: begin
				case ($urandom_range(0, 4))
					0: v = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
					2: v = '0;
					3: v = '1;
					default: v = SAMPLE_WIDTH'(1);
				endcase
			end
			default: begin
				v = SAMPLE_WIDTH'($urandom_range(0, 255)) << $urandom_range(0, SAMPLE_WIDTH - 8);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic sample_t random_sample();
		int unsigned kind;
		int unsigned lead;
		sample_t s;
		kind = $urandom_range(0, 19);
		if (kind <= 8) begin
			s = pack_sample(random_axis(0), random_axis(0), random_axis(0));
		end else if (kind <= 11) begin
			s = pack_sample(random_axis(1), random_axis(1), random_axis(1));
		end else if (kind <= 13) begin
			s = pack_sample(random_axis(2), random_axis(2), random_axis(2));
		end else if (kind <= 16) begin
			s = pack_sample(random_axis($urandom_range(0, 3)), random_axis($urandom_range(0, 3)),
				random_axis($urandom_range(0, 3)));
		end else if (kind <= 18) begin
			// One large axis against two tiny ones
			lead = $urandom_range(0, 2);
			s = pack_sample(random_axis(lead == 0 ? 0 : 1), random_axis(lead == 1 ? 0 : 1),
				random_axis(lead == 2 ? 0 : 1));
		end else begin
			s = '0;
		end
		return s;
	endfunction

	// Hold start and the sample until the transfer edge
	task automatic send_sample(sample_t s);
		logic was_busy;
		start <= 1'b1;
		sample <= s;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		sb.note_sample(s);
	endtask

	task automatic rest_cycle();
		start <= 1'b0;
		sample <= random_sample();
		@(posedge clk);
	endtask

	// Drop start and wait out every pending result
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_dirs.size() != 0);
	endtask

	task automatic run_phase(int count, int unsigned idle_pct);
		repeat (count) begin
			while ($urandom_range(0, 99) < idle_pct)
				rest_cycle();
			send_sample(random_sample());
		end
	endtask

	task automatic run_directed();
		send_sample(pack_sample(0, 0, 0));
		send_sample(pack_sample(32767, 0, 0));
		send_sample(pack_sample(-32768, 0, 0));
		send_sample(pack_sample(0, -32768, 0));
		send_sample(pack_sample(0, 32767, 0));
		send_sample(pack_sample(0, 0, 32767));
		send_sample(pack_sample(0, 0, -1));
		send_sample(pack_sample(32767, 32767, 32767));
		send_sample(pack_sample(-32768, -32768, -32768));
		send_sample(pack_sample(1, 0, 0));
		send_sample(pack_sample(-1, 0, 0));
		send_sample(pack_sample(1, 1, 1));
		send_sample(pack_sample(-1, -1, -1));
		send_sample(pack_sample(32767, -32768, 1));
		send_sample(pack_sample(1, 32767, 0));
		send_sample(pack_sample(3, 4, 0));
		send_sample(pack_sample(12, -5, 0));
		send_sample(pack_sample(-32768, 32767, -32768));
		send_sample(pack_sample(0, 0, 0));
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		sample <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners back to back, then a full drain
		run_directed();
		wait_drained();

		// Random samples under three idle mixes, draining between them
		run_phase(640, 14);
		wait_drained();
		run_phase(640, 65);
		wait_drained();
		run_phase(640, 0);
		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);

		$display("Checked %0d directions (%0d all-zero) over corner, random and drained runs.",
			sb.matched, sb.zero_hits);
		$display("Mismatches or stray results: %0d", sb.errors);
		if (sb.errors == 0 && sb.pending_dirs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
